// File: hdl/sca_pkg.sv
// shared types and constants of the sample covariance accumulator
// no dependencies; imported by the controller, the datapath and the top level
package sca_pkg;

    localparam int COV_W  = 40;
    localparam int CNT_W  = 13;
    localparam int STAT_W = 2;
    // covariance, pair count, padded to whole bytes
    localparam int OUT_DATA_W = ((COV_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_ZERO_DIV = 2'd1,
        STAT_TOO_MANY = 2'd2
    } sca_status_t;

    typedef struct packed {
        logic capture;
        logic accumulate;
        logic multiply;
        logic prepare;
        logic div_step;
        logic load_out;
    } sca_cmd_t;

    typedef struct packed {
        logic last;
    } sca_flags_t;

    // bits of the rounded dividend, i.e. quotient bits of the restoring divider
    function automatic int sca_div_bits(input int max_pairs, input int sample_bits,
                                        input int frac_bits);
        int l;
        int cw;
        int sxw;
        int spw;
        int p1w;
        int p2w;
        int nw;
        l   = $clog2(max_pairs);
        cw  = $clog2(max_pairs + 1);
        sxw = sample_bits + l + 1;
        spw = 2 * sample_bits + l;
        p1w = cw + 1 + spw;
        p2w = 2 * sxw;
        nw  = ((p1w > p2w) ? p1w : p2w) + 1;
        return nw + frac_bits + 1;
    endfunction

endpackage

// File: hdl/sca_ctrl.sv
// sequencer of the covariance accumulator: accumulate, multiply, divide, output
// uses sca_pkg; drives the command struct of sca_datapath
module sca_ctrl
    import sca_pkg::*;
#(
    parameter int DIV_STEPS = 67
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  sca_flags_t flags,
    output sca_cmd_t   cmd
);

    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_MUL,
        S_PREP,
        S_DIV,
        S_FIN
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next     = flags.last ? S_MUL : S_IDLE;
            end
            S_MUL:
            begin
                cmd.multiply = 1'b1;
                state_next   = S_PREP;
            end
            S_PREP:
            begin
                cmd.prepare = 1'b1;
                step_next   = '0;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // wait until the output register has been emptied
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hdl/sca_datapath.sv
// datapath of the covariance accumulator: sums, cross products, restoring divider
// uses sca_pkg; sequenced by sca_ctrl
module sca_datapath
    import sca_pkg::*;
#(
    parameter int MAX_PAIRS     = 4096,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sca_cmd_t                      cmd,
    output sca_flags_t                    flags,
    input  logic                          cfg_valid,
    input  logic                          cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] x_sample,
    input  logic signed [SAMPLE_BITS-1:0] y_sample,
    input  logic                          last_sample,
    output logic signed [COV_W-1:0]       covariance,
    output logic [CNT_W-1:0]              pair_count,
    output logic [STAT_W-1:0]             status
);

    localparam int L     = $clog2(MAX_PAIRS);
    localparam int CW    = $clog2(MAX_PAIRS + 1);
    localparam int SXW   = SAMPLE_BITS + L + 1;
    localparam int PRW   = 2 * SAMPLE_BITS;
    localparam int SPW   = 2 * SAMPLE_BITS + L;
    localparam int P1W   = CW + 1 + SPW;
    localparam int P2W   = 2 * SXW;
    localparam int NW    = ((P1W > P2W) ? P1W : P2W) + 1;
    localparam int DW    = sca_div_bits(MAX_PAIRS, SAMPLE_BITS, FRACTION_BITS);
    localparam int DENW  = 2 * CW;
    localparam int QW    = (DW > COV_W) ? DW : COV_W;

    logic                    mode_reg;
    logic                    last_reg;
    logic signed [PRW-1:0]   prod_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;

    logic [CW-1:0]           cnt_reg;
    logic signed [SXW-1:0]   sx_reg;
    logic signed [SXW-1:0]   sy_reg;
    logic signed [SPW-1:0]   sxy_reg;
    logic                    ovf_reg;

    logic signed [P1W-1:0]   p1_reg;
    logic signed [P2W-1:0]   p2_reg;
    logic [DENW-1:0]         den_reg;
    logic [CW-1:0]           n_reg;
    sca_status_t             st_reg;

    logic                    neg_reg;
    logic [DW-1:0]           quo_reg;
    logic [DENW-1:0]         rem_reg;

    logic signed [COV_W-1:0] cov_out_reg;
    logic [CNT_W-1:0]        cnt_out_reg;
    sca_status_t             st_out_reg;

    logic [CW-1:0]           n_other;
    sca_status_t             st_next;
    logic signed [NW-1:0]    num;
    logic [NW-1:0]           mag;
    logic [DENW:0]           rem_shift;
    logic [DENW:0]           rem_diff;
    logic                    q_bit;
    logic [QW-1:0]           q_ext;
    logic [QW-1:0]           limit;
    logic [QW-1:0]           q_sat;
    logic [COV_W-1:0]        cov_mag;
    logic signed [COV_W-1:0] cov_next;

    assign flags.last = last_reg;

    always_comb
    begin
        n_other = mode_reg ? (cnt_reg - 1'b1) : cnt_reg;
        if (ovf_reg)
        begin
            st_next = STAT_TOO_MANY;
        end
        else if ((cnt_reg == '0) || (mode_reg && (cnt_reg == CW'(1))))
        begin
            st_next = STAT_ZERO_DIV;
        end
        else
        begin
            st_next = STAT_OK;
        end

        num = NW'(p1_reg) - NW'(p2_reg);
        mag = num[NW-1] ? NW'(-num) : NW'(num);

        // one restoring step per cycle, quotient bits shift in behind the dividend
        rem_shift = {rem_reg, quo_reg[DW-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        q_bit     = !rem_diff[DENW];

        q_ext   = QW'(quo_reg);
        limit   = neg_reg ? (QW'(1) << (COV_W - 1)) : ((QW'(1) << (COV_W - 1)) - 1'b1);
        q_sat   = (q_ext > limit) ? limit : q_ext;
        cov_mag = q_sat[COV_W-1:0];
        if (st_reg != STAT_OK)
        begin
            cov_next = '0;
        end
        else
        begin
            cov_next = neg_reg ? $signed(-cov_mag) : $signed(cov_mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            last_reg <= 1'b0;
            cnt_reg  <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            sxy_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            if (cmd.capture)
            begin
                last_reg <= last_sample;
            end
            if (cmd.accumulate)
            begin
                if (cnt_reg < CW'(MAX_PAIRS))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    sx_reg  <= sx_reg + SXW'(x_reg);
                    sy_reg  <= sy_reg + SXW'(y_reg);
                    sxy_reg <= sxy_reg + SPW'(prod_reg);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            // the column is finished once the cross products are registered
            if (cmd.prepare)
            begin
                cnt_reg <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
                sxy_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg    <= x_sample;
            y_reg    <= y_sample;
            prod_reg <= x_sample * y_sample;
        end
        if (cmd.multiply)
        begin
            p1_reg  <= $signed({1'b0, cnt_reg}) * sxy_reg;
            p2_reg  <= sx_reg * sy_reg;
            den_reg <= cnt_reg * n_other;
            n_reg   <= cnt_reg;
            st_reg  <= st_next;
        end
        if (cmd.prepare)
        begin
            // round to nearest: add half the divisor before dividing
            neg_reg <= num[NW-1];
            quo_reg <= (DW'(mag) << FRACTION_BITS) + DW'(den_reg >> 1);
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[DW-2:0], q_bit};
            rem_reg <= q_bit ? rem_diff[DENW-1:0] : rem_shift[DENW-1:0];
        end
        if (cmd.load_out)
        begin
            cov_out_reg <= cov_next;
            cnt_out_reg <= CNT_W'(n_reg);
            st_out_reg  <= st_reg;
        end
    end

    assign covariance = cov_out_reg;
    assign pair_count = cnt_out_reg;
    assign status     = st_out_reg;

endmodule

// File: hdl/sample_covariance_accumulator_top.sv
// top level of the sample covariance accumulator: stream ports, sca_ctrl, sca_datapath
// uses sca_pkg
// each sample pair passes a capture and product state, then an accumulate state
// a last pair then passes the multiply and prepare states for the cross products and
// the one-bit-a-step restoring divider, DIV_BITS = 68 steps at the defaults, before
// the result is shown; the output register frees the input while a result waits
// reset clears the sums, the pair count, the divisor mode and the output valid
module sample_covariance_accumulator_top
    import sca_pkg::*;
#(
    parameter int MAX_PAIRS     = 4096,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic                                     cfg_data,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // x_sample, y_sample, zero padding
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
    input  logic                                     s_tlast,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // covariance, pair_count, zero padding
    output logic [OUT_DATA_W-1:0]                    m_tdata,
    // status
    output logic [STAT_W-1:0]                        m_tuser
);

    localparam int DIV_BITS = sca_div_bits(MAX_PAIRS, SAMPLE_BITS, FRACTION_BITS);

    sca_cmd_t                cmd;
    sca_flags_t              flags;
    logic signed [COV_W-1:0] covariance;
    logic [CNT_W-1:0]        pair_count;

    assign cfg_ready = 1'b1;

    sca_ctrl #(
        .DIV_STEPS (DIV_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    sca_datapath #(
        .MAX_PAIRS     (MAX_PAIRS),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .flags       (flags),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .x_sample    ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .y_sample    ($signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .last_sample (s_tlast),
        .covariance  (covariance),
        .pair_count  (pair_count),
        .status      (m_tuser)
    );

    assign m_tdata = OUT_DATA_W'({pair_count, covariance});

endmodule

// File: test/tb_sample_covariance_accumulator_top.sv
// self-checking testbench for sample_covariance_accumulator_top
// predicts each column's covariance, pair count and status and checks every result item
// depends on sca_pkg and the top level only
module tb_sample_covariance_accumulator_top;
    import sca_pkg::*;

    localparam int PAIR_LIMIT   = 4096;
    localparam int SAMPLE_W     = 16;
    localparam int FRAC_W       = 8;
    localparam int IN_DATA_W    = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_PAIRS = 1900;

    localparam bit [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam bit [SAMPLE_W-1:0] S_MAX = ~S_MIN;
    localparam bit [SAMPLE_W-1:0] S_ONE = SAMPLE_W'(1);
    localparam bit [SAMPLE_W-1:0] S_NEG = '1;

    typedef struct {
        bit [SAMPLE_W-1:0] x;
        bit [SAMPLE_W-1:0] y;
        bit                last;
        int                gap;
    } pair_item_t;

    typedef struct {
        logic [COV_W-1:0] cov;
        logic [CNT_W-1:0] cnt;
        sca_status_t      status;
    } column_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_data  = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;

    pair_item_t     pending_pairs[$];
    column_result_t expected_columns[$];
    pair_item_t     drive_pair;
    column_result_t oldest_col;

    int errors       = 0;
    int random_pairs = 0;
    bit quiet_col    = 1'b0;
    bit quiet_out    = 1'b0;
    bit in_taken     = 1'b0;
    bit out_taken    = 1'b0;
    bit gap_armed    = 1'b0;
    int gap_left     = 0;
    int out_stall    = 0;

    // running column state of the predictor
    int        col_count = 0;
    bit [63:0] col_sx    = '0;
    bit [63:0] col_sy    = '0;
    bit [63:0] col_sxy   = '0;
    bit        col_over  = 1'b0;
    bit        div_by_nm1 = 1'b0;

    sample_covariance_accumulator_top #(
        .MAX_PAIRS     (PAIR_LIMIT),
        .SAMPLE_BITS   (SAMPLE_W),
        .FRACTION_BITS (FRAC_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // num * 2^FRAC_W / d rounded half away from zero, clamped to the covariance range
    function automatic bit [63:0] scaled_round_div(bit [63:0] num, bit [63:0] d);
        bit        neg;
        bit [63:0] mag;
        bit [63:0] lim;
        bit [63:0] q;
        bit [63:0] r;
        bit [63:0] res;
        neg = num[63];
        mag = neg ? -num : num;
        lim = neg ? (64'd1 << (COV_W - 1)) : ((64'd1 << (COV_W - 1)) - 64'd1);
        q   = mag / d;
        r   = mag % d;
        if (q > (lim >> FRAC_W))
            res = lim;
        else
        begin
            res = (q << FRAC_W) + (((r << FRAC_W) + d / 64'd2) / d);
            if (res > lim)
                res = lim;
        end
        return neg ? -res : res;
    endfunction

    function automatic void accumulate_pair(bit [SAMPLE_W-1:0] x, bit [SAMPLE_W-1:0] y,
                                            bit last);
        bit [63:0]      xe;
        bit [63:0]      ye;
        bit [63:0]      n;
        bit [63:0]      d;
        bit [63:0]      q;
        column_result_t res;
        xe = {{(64-SAMPLE_W){x[SAMPLE_W-1]}}, x};
        ye = {{(64-SAMPLE_W){y[SAMPLE_W-1]}}, y};
        if (col_count < PAIR_LIMIT)
        begin
            col_count++;
            col_sx  += xe;
            col_sy  += ye;
            col_sxy += xe * ye;
        end
        else
            col_over = 1'b1;
        if (last)
        begin
            n = 64'(col_count);
            if (div_by_nm1)
                d = (n == 0) ? 64'd0 : n * (n - 64'd1);
            else
                d = n * n;
            res.cov = '0;
            res.cnt = n[CNT_W-1:0];
            if (col_over)
                res.status = STAT_TOO_MANY;
            else if (d == 0)
                res.status = STAT_ZERO_DIV;
            else
            begin
                res.status = STAT_OK;
                q = scaled_round_div(n * col_sxy - col_sx * col_sy, d);
                res.cov = q[COV_W-1:0];
            end
            expected_columns.push_back(res);
            col_count = 0;
            col_sx    = '0;
            col_sy    = '0;
            col_sxy   = '0;
            col_over  = 1'b0;
        end
    endfunction

    // 0 full range, 1 corner values, 2 small magnitudes, otherwise a mix
    function automatic bit [SAMPLE_W-1:0] draw_sample(int style);
        int pick;
        pick = (style > 2) ? $urandom_range(0, 2) : style;
        if (pick == 0)
            return SAMPLE_W'($urandom);
        if (pick == 1)
        begin
            case ($urandom_range(0, 4))
                0:       return S_MIN;
                1:       return S_MAX;
                2:       return '0;
                3:       return S_NEG;
                default: return S_ONE;
            endcase
        end
        return SAMPLE_W'($urandom_range(0, 64)) - SAMPLE_W'(32);
    endfunction

    task automatic push_pair(bit [SAMPLE_W-1:0] x, bit [SAMPLE_W-1:0] y, bit last);
        pair_item_t it;
        it.x    = x;
        it.y    = y;
        it.last = last;
        it.gap  = quiet_col ? 0 : $urandom_range(0, 19);
        pending_pairs.push_back(it);
    endtask

    task automatic push_column(int len, int style);
        quiet_col = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
            push_pair(draw_sample(style), draw_sample(style), i == len - 1);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_pairs.size() != 0 || s_tvalid || expected_columns.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_divisor_mode(bit mode);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // input side: one item at a time, each after its own gap
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !in_taken))
        begin
            if (pending_pairs.size() == 0)
                s_tvalid <= 1'b0;
            else
            begin
                if (!gap_armed)
                begin
                    gap_left  = pending_pairs[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    drive_pair = pending_pairs.pop_front();
                    gap_armed  = 1'b0;
                    s_tvalid  <= 1'b1;
                    s_tdata   <= IN_DATA_W'({drive_pair.y, drive_pair.x});
                    s_tlast   <= drive_pair.last;
                end
            end
        end
    end

    // output side: the stall drawn per result only runs down while a result is shown
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                out_stall = quiet_out ? 0 : $urandom_range(0, 19);
            if (m_tvalid && out_stall > 0)
                out_stall--;
            m_tready <= (out_stall == 0);
        end
    end

    always @(posedge clk)
    begin
        in_taken  = rst_n && s_tvalid && s_tready;
        out_taken = rst_n && m_tvalid && m_tready;
        if (rst_n && cfg_valid && cfg_ready)
            div_by_nm1 = cfg_data;
        if (in_taken)
            accumulate_pair(s_tdata[SAMPLE_W-1:0], s_tdata[2*SAMPLE_W-1:SAMPLE_W], s_tlast);
        if (out_taken)
        begin
            if (expected_columns.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual cov %h count %0d status %0d",
                         $time, m_tdata[COV_W-1:0], m_tdata[COV_W+CNT_W-1:COV_W], m_tuser);
            end
            else
            begin
                oldest_col = expected_columns.pop_front();
                if (m_tdata[COV_W-1:0] !== oldest_col.cov)
                begin
                    errors++;
                    $display("%0t: covariance expected %h actual %h",
                             $time, oldest_col.cov, m_tdata[COV_W-1:0]);
                end
                if (m_tdata[COV_W+CNT_W-1:COV_W] !== oldest_col.cnt)
                begin
                    errors++;
                    $display("%0t: pair_count expected %0d actual %0d",
                             $time, oldest_col.cnt, m_tdata[COV_W+CNT_W-1:COV_W]);
                end
                if (m_tuser !== oldest_col.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest_col.status, m_tuser);
                end
            end
        end
    end

    initial
    begin
        #30000000;
        $display("sample_covariance_accumulator_top regression: fail");
        $finish;
    end

    initial
    begin
        int len;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // population mode corners
        write_divisor_mode(1'b0);
        quiet_col = 1'b0;
        push_pair(S_MAX, S_MAX, 1'b1);
        push_pair(S_MIN, S_MIN, 1'b0);
        push_pair(S_MAX, S_MAX, 1'b1);
        push_pair(S_MIN, S_MAX, 1'b0);
        push_pair(S_MAX, S_MIN, 1'b1);
        push_pair('0, '0, 1'b0);
        push_pair(S_NEG, S_ONE, 1'b0);
        push_pair(SAMPLE_W'(5), -SAMPLE_W'(3), 1'b1);
        wait_idle();

        // sample mode corners, a single pair gives a zero divisor
        write_divisor_mode(1'b1);
        quiet_col = 1'b1;
        push_pair(SAMPLE_W'(100), -SAMPLE_W'(100), 1'b1);
        push_pair(S_MIN, S_MIN, 1'b0);
        push_pair(S_MAX, S_MAX, 1'b1);
        push_pair(S_MIN, S_MAX, 1'b0);
        push_pair(S_MAX, S_MIN, 1'b0);
        push_pair(S_ONE, SAMPLE_W'(2), 1'b1);
        push_pair(S_NEG, S_NEG, 1'b0);
        push_pair('0, '0, 1'b1);
        wait_idle();

        while (random_pairs < RANDOM_PAIRS)
        begin
            write_divisor_mode(1'($urandom_range(0, 1)));
            quiet_out = ($urandom_range(0, 3) == 0);
            repeat (8)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                                  : $urandom_range(1, 40);
                push_column(len, $urandom_range(0, 3));
                random_pairs += len;
            end
            wait_idle();
        end

        if (errors == 0)
            $display("sample_covariance_accumulator_top regression: pass");
        else
            $display("sample_covariance_accumulator_top regression: fail");
        $finish;
    end

endmodule
